// ===== sv/shabs_pkg.sv =====
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package shabs_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMPRESS,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_PAD,
    SRC_ZERO,
    SRC_LENGTH
  } byte_src_t;

  typedef struct packed {
    logic       absorb;      // shift one byte into the block window
    byte_src_t  src;
    logic       count_byte;  // message byte, bump the length counter
    logic       load_work;   // copy chain words into working registers
    logic       round;       // run one compression round
    logic [5:0] round_idx;
    logic       finalize;    // add working registers into chain words
    logic       init;        // start a new message
    logic [2:0] word_idx;    // digest word on the output
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      default: w = 32'h5be0cd19;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/shabs_if.sv =====
// Valid/ready stream interfaces for message items and digest words.
// No dependencies.
`default_nettype none
interface shabs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface shabs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== sv/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream: one optional message byte per input transfer,
// eight big-endian digest words out after an end-of-message transfer.
// Depends on shabs_pkg, shabs_if, shabs_ctrl and shabs_datapath.
//
// A transfer carrying a byte is taken while the hasher is idle. Every 64th
// byte (message or padding) starts a block compression of 64 rounds, one
// round per cycle, then the result is folded into the chain words; input is
// held off until both are done. At end of message the padding and length
// bytes are fed one per cycle outside compressions (up to 72 bytes, with one
// or two compressions), then the eight digest words come out one per
// transfer, word 0 first, and the hasher restarts for the next message.
`default_nettype none
module sha256_byte_stream_hasher (
  input wire logic    clk,
  input wire logic    rst,
  shabs_in_if.sink    in_ch,
  shabs_out_if.source out_ch
);

  shabs_pkg::cmd_t    cmd;
  shabs_pkg::status_t stat;

  shabs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_has_byte (in_ch.has_byte),
    .in_end      (in_ch.end_of_message),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_last    (out_ch.last_word),
    .stat        (stat),
    .cmd         (cmd)
  );

  shabs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (out_ch.digest_word)
  );

  assign out_ch.word_index = cmd.word_idx;

endmodule
`default_nettype wire

// ===== sv/shabs_ctrl.sv =====
// Sequencer for the hasher: input intake, padding, rounds and digest output.
// Depends on shabs_pkg.
`default_nettype none
module shabs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_has_byte,
  input  wire logic             in_end,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_last,
  input  wire shabs_pkg::status_t stat,
  output shabs_pkg::cmd_t       cmd
);

  shabs_pkg::state_t state, state_next;
  logic [5:0] round_cnt;
  logic [2:0] word_idx;
  logic       fin_pending;
  logic       pad_first;
  logic       len_phase;
  logic       len_done;
  logic       accept;
  logic       wrap;
  logic       out_xfer;

  assign accept   = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign wrap     = cmd.absorb && (stat.fill == 6'(shabs_pkg::BlockBytes - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      shabs_pkg::ST_IDLE: begin
        if (wrap) state_next = shabs_pkg::ST_COMPRESS;
        else if (accept && in_end) state_next = shabs_pkg::ST_PAD;
      end
      shabs_pkg::ST_PAD: begin
        if (wrap) state_next = shabs_pkg::ST_COMPRESS;
      end
      shabs_pkg::ST_COMPRESS: begin
        if (round_cnt == 6'd63) state_next = shabs_pkg::ST_ADD;
      end
      shabs_pkg::ST_ADD: begin
        if (!fin_pending) state_next = shabs_pkg::ST_IDLE;
        else if (len_done) state_next = shabs_pkg::ST_OUT;
        else state_next = shabs_pkg::ST_PAD;
      end
      shabs_pkg::ST_OUT: begin
        if (out_xfer && word_idx == 3'd7) state_next = shabs_pkg::ST_IDLE;
      end
      default: state_next = shabs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = (word_idx == 3'd7);
    cmd       = '0;
    cmd.src   = shabs_pkg::SRC_INPUT;
    cmd.round_idx = round_cnt;
    cmd.word_idx  = word_idx;
    unique case (state)
      shabs_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.absorb     = accept && in_has_byte;
        cmd.count_byte = accept && in_has_byte;
      end
      shabs_pkg::ST_PAD: begin
        cmd.absorb = 1'b1;
        // length goes in at offsets 56..63 of the last block only
        if (pad_first) cmd.src = shabs_pkg::SRC_PAD;
        else if (len_phase || stat.fill == 6'(shabs_pkg::LenOffset))
          cmd.src = shabs_pkg::SRC_LENGTH;
        else cmd.src = shabs_pkg::SRC_ZERO;
      end
      shabs_pkg::ST_COMPRESS: cmd.round = 1'b1;
      shabs_pkg::ST_ADD: cmd.finalize = 1'b1;
      shabs_pkg::ST_OUT: begin
        out_valid = 1'b1;
        cmd.init  = out_xfer && word_idx == 3'd7;
      end
      default: ;
    endcase
    cmd.load_work = wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= shabs_pkg::ST_IDLE;
      round_cnt   <= '0;
      word_idx    <= '0;
      fin_pending <= 1'b0;
      pad_first   <= 1'b0;
      len_phase   <= 1'b0;
      len_done    <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.round) round_cnt <= round_cnt + 6'd1;
      if (out_xfer) word_idx <= word_idx + 3'd1;
      if (accept && in_end) begin
        fin_pending <= 1'b1;
        pad_first   <= 1'b1;
      end else if (state == shabs_pkg::ST_PAD) begin
        pad_first <= 1'b0;
      end
      if (state == shabs_pkg::ST_PAD && !pad_first &&
          stat.fill == 6'(shabs_pkg::LenOffset)) len_phase <= 1'b1;
      // wrap on a length byte closes the final block
      if (state == shabs_pkg::ST_PAD && wrap && cmd.src == shabs_pkg::SRC_LENGTH)
        len_done <= 1'b1;
      if (cmd.init) begin
        fin_pending <= 1'b0;
        len_phase   <= 1'b0;
        len_done    <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/shabs_datapath.sv =====
// Block window, message schedule, round logic and chain words of the hasher.
// Depends on shabs_pkg.
`default_nettype none
module shabs_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        data_byte,
  input  wire shabs_pkg::cmd_t   cmd,
  output shabs_pkg::status_t     stat,
  output logic [31:0]            digest_word
);

  logic [511:0] window;       // 64-byte block, first byte at the top
  logic [31:0]  chain [8];
  logic [31:0]  work  [8];
  logic [5:0]   fill;
  logic [63:0]  byte_count;
  logic [63:0]  len_bits;
  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  sig0, sig1, big0, big1, choose, major, t1, t2;

  assign len_bits = {byte_count[60:0], 3'b000};

  always_comb begin
    case (cmd.src)
      shabs_pkg::SRC_INPUT:  byte_in = data_byte;
      shabs_pkg::SRC_PAD:    byte_in = shabs_pkg::PadByte;
      shabs_pkg::SRC_ZERO:   byte_in = 8'h00;
      default:               byte_in = len_bits[{~fill[2:0], 3'b000} +: 8];
    endcase
  end

  assign w0  = window[511:480];
  assign w1  = window[479:448];
  assign w9  = window[223:192];
  assign w14 = window[63:32];

  assign sig0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign sig1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign w_new = w0 + sig0 + w9 + sig1;

  assign big1   = {work[4][5:0], work[4][31:6]} ^ {work[4][10:0], work[4][31:11]}
                ^ {work[4][24:0], work[4][31:25]};
  assign choose = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign t1     = work[7] + big1 + choose + shabs_pkg::round_const(cmd.round_idx) + w0;
  assign big0   = {work[0][1:0], work[0][31:2]} ^ {work[0][12:0], work[0][31:13]}
                ^ {work[0][21:0], work[0][31:22]};
  assign major  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t2     = big0 + major;

  always_ff @(posedge clk) begin
    if (cmd.absorb) window <= {window[503:0], byte_in};
    else if (cmd.round) window <= {window[479:0], w_new};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) work[i] <= chain[i];
    end else if (cmd.round) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= shabs_pkg::init_word(3'(i));
      fill       <= '0;
      byte_count <= '0;
    end else begin
      if (cmd.finalize) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
      end
      if (cmd.absorb) fill <= fill + 6'd1;
      if (cmd.count_byte) byte_count <= byte_count + 64'd1;
    end
  end

  assign stat.fill   = fill;
  assign digest_word = chain[cmd.word_idx];

endmodule
`default_nettype wire
